// ===== src/keyed_record_table_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the keyed record table unit
// Shared helpers that wrap clocked implication properties.
// ----------------------------------------------------------------------------
`ifndef KEYED_RECORD_TABLE_UNIT_ASSERT_SVH
`define KEYED_RECORD_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge
`define KRT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("keyed record table: check failed");

// Next-cycle implication, sampled on the rising clock edge
`define KRT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("keyed record table: check failed");

`endif

// ===== src/krt_pkg.sv =====
// ----------------------------------------------------------------------------
// Keyed record table package
// Shared types, sizes and codes of the record table.
// ----------------------------------------------------------------------------
package krt_pkg;

  localparam int TableDepth = 16;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int CntW       = $clog2(TableDepth + 1);

  typedef enum logic [1:0] {
    REQ_ADD  = 2'd0,
    REQ_DEL  = 2'd1,
    REQ_READ = 2'd2,
    REQ_LIST = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_DUP     = 3'd2,
    ST_MISSING = 3'd3,
    ST_CLAMPED = 3'd4
  } status_e;

  typedef struct packed {
    logic [31:0] key;
    logic [7:0]  year;
    logic [15:0] id_one;
    logic [7:0]  grade_one;
    logic [15:0] id_two;
    logic [7:0]  grade_two;
    logic [15:0] id_three;
    logic [7:0]  grade_three;
  } rec_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

  typedef struct packed {
    status_e          status;
    logic [IdxW-1:0]  slot;
    logic [CntW-1:0]  used;
    logic             last;
    rec_t             rec;
  } res_t;

endpackage

// ===== src/krt_cell.sv =====
// ----------------------------------------------------------------------------
// Record table cell
// Holds one record; takes its neighbour's record on a shift, or a new one.
// ----------------------------------------------------------------------------
module krt_cell (
  input  logic              clk_i,
  input  krt_pkg::cell_ctl_t ctl_i,
  input  krt_pkg::rec_t     nbr_i,
  input  krt_pkg::rec_t     load_rec_i,
  output krt_pkg::rec_t     rec_o
);

  krt_pkg::rec_t rec_q;
  krt_pkg::rec_t rec_d;

  // Load wins over shift; otherwise hold
  always_comb begin
    rec_d = rec_q;
    if (ctl_i.load) begin
      rec_d = load_rec_i;
    end else if (ctl_i.shift) begin
      rec_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o = rec_q;

endmodule

// ===== src/keyed_record_table_unit.sv =====
// ----------------------------------------------------------------------------
// Keyed record table unit
// Record table held in a ring of cells, searched by rotating it past a head.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_axis slave channel: tuser carries the request
//   kind (add, delete, read, list), tdata the key, record fields and list
//   count. Results leave on the m_axis master channel, one word per request,
//   or one word per listed key with tlast on the final one.
//   Each request rotates the ring of sixteen cells once, one slot passing
//   the comparator at the head each cycle unless a list word stalls it,
//   then takes a finish step for the table update and result; the next
//   request is taken in the cycle after that step.
//   Add, delete and read results are registered in the finish step; list
//   words follow at one per cycle while the receiver keeps up.
//   A new request is taken only once the previous one has finished.
//   When the receiver stalls, the result register holds its word and a
//   list rotation or the finish step waits; nothing is lost.
//   Reset clears the record count and the control state; record contents
//   are not cleared and are never shown before they are written.
// ----------------------------------------------------------------------------
`include "keyed_record_table_unit_assert.svh"

module keyed_record_table_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: student_key, entry_year, course_one_id, course_one_grade,
  //        course_two_id, course_two_grade, course_three_id,
  //        course_three_grade, list_count
  input  logic [119:0] s_axis_tdata,
  // tuser: req_type
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: status, slot_index, used_count, out_key, out_year,
  //        out_course_one_id, out_course_one_grade, out_course_two_id,
  //        out_course_two_grade, out_course_three_id,
  //        out_course_three_grade, zero fill
  output logic [127:0] m_axis_tdata,
  // tlast: last_of_run
  output logic         m_axis_tlast
);

  localparam int Depth = krt_pkg::TableDepth;
  localparam int IdxW  = krt_pkg::IdxW;
  localparam int CntW  = krt_pkg::CntW;

  typedef enum logic [2:0] {
    IDLE   = 3'b001,
    SCAN   = 3'b010,
    FINISH = 3'b100
  } state_e;

  state_e             state_q, state_d;
  krt_pkg::req_e      req_q;
  krt_pkg::rec_t      in_rec_q;
  krt_pkg::rec_t      cap_q;
  krt_pkg::rec_t      last_rec_q;
  logic [IdxW-1:0]    step_q;
  logic [IdxW-1:0]    found_idx_q;
  logic               found_q;
  logic [CntW-1:0]    count_q, count_d;
  logic [CntW-1:0]    n_q;
  logic               clamp_q;
  logic               out_valid_q, out_valid_d;
  krt_pkg::res_t      out_q, out_d;

  krt_pkg::rec_t      cell_rec [Depth];
  krt_pkg::rec_t      in_rec;
  krt_pkg::rec_t      head;
  krt_pkg::rec_t      wr_rec;
  logic               wr_en;
  logic [IdxW-1:0]    wr_idx;
  logic               shift;
  logic               out_free;
  logic               accept;
  logic               head_used;
  logic               match;
  logic               list_emit;
  logic               step_last;
  logic [7:0]         lc;
  logic [CntW-1:0]    count_dec;

  // Unpack the request word
  assign in_rec.key         = s_axis_tdata[31:0];
  assign in_rec.year        = s_axis_tdata[39:32];
  assign in_rec.id_one      = s_axis_tdata[55:40];
  assign in_rec.grade_one   = s_axis_tdata[63:56];
  assign in_rec.id_two      = s_axis_tdata[79:64];
  assign in_rec.grade_two   = s_axis_tdata[87:80];
  assign in_rec.id_three    = s_axis_tdata[103:88];
  assign in_rec.grade_three = s_axis_tdata[111:104];
  assign lc                 = s_axis_tdata[119:112];

  assign s_axis_tready = (state_q == IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // Ring of cells: each takes its upper neighbour, the head wraps round
  assign head = cell_rec[0];
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    krt_pkg::cell_ctl_t ctl;
    assign ctl.shift = shift;
    assign ctl.load  = wr_en && (wr_idx == IdxW'(i));
    krt_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .nbr_i      (cell_rec[(i + 1) % Depth]),
      .load_rec_i (wr_rec),
      .rec_o      (cell_rec[i])
    );
  end

  // Head comparison during the rotation
  assign head_used = ({1'b0, step_q} < count_q);
  assign match     = (state_q == SCAN) && head_used && !found_q &&
                     (head.key == in_rec_q.key);
  assign list_emit = (state_q == SCAN) && (req_q == krt_pkg::REQ_LIST) &&
                     ({1'b0, step_q} < n_q);
  assign shift     = (state_q == SCAN) && (!list_emit || out_free);
  assign step_last = (step_q == IdxW'(Depth - 1));
  assign count_dec = count_q - CntW'(1);

  // Sequencer, table update and result formation
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_d       = out_q;
    wr_en       = 1'b0;
    wr_idx      = found_idx_q;
    wr_rec      = last_rec_q;
    unique case (state_q)
      IDLE: begin
        if (accept) begin
          state_d = SCAN;
        end
      end
      SCAN: begin
        if (list_emit && out_free) begin
          out_valid_d     = 1'b1;
          out_d           = '0;
          out_d.status    = clamp_q ? krt_pkg::ST_CLAMPED : krt_pkg::ST_OK;
          out_d.slot      = step_q;
          out_d.used      = count_q;
          out_d.last      = ({1'b0, step_q} + CntW'(1) == n_q);
          out_d.rec.key   = head.key;
        end
        if (shift && step_last) begin
          state_d = FINISH;
        end
      end
      FINISH: begin
        if (out_free) begin
          state_d     = IDLE;
          out_d       = '0;
          out_d.last  = 1'b1;
          out_valid_d = 1'b1;
          case (req_q)
            krt_pkg::REQ_ADD: begin
              if (count_q >= CntW'(Depth)) begin
                out_d.status = krt_pkg::ST_FULL;
              end else if (found_q) begin
                out_d.status = krt_pkg::ST_DUP;
                out_d.slot   = found_idx_q;
              end else begin
                wr_en        = 1'b1;
                wr_idx       = count_q[IdxW-1:0];
                wr_rec       = in_rec_q;
                count_d      = count_q + CntW'(1);
                out_d.status = krt_pkg::ST_OK;
                out_d.slot   = count_q[IdxW-1:0];
              end
            end
            krt_pkg::REQ_DEL: begin
              if (found_q) begin
                wr_en        = 1'b1;
                count_d      = count_dec;
                out_d.status = krt_pkg::ST_OK;
                out_d.slot   = found_idx_q;
              end else begin
                out_d.status = krt_pkg::ST_MISSING;
              end
            end
            krt_pkg::REQ_READ: begin
              if (found_q) begin
                out_d.status = krt_pkg::ST_OK;
                out_d.slot   = found_idx_q;
                out_d.rec    = cap_q;
              end else begin
                out_d.status = krt_pkg::ST_MISSING;
              end
            end
            default: begin
              // Empty list gives a single closing word
              out_valid_d  = (n_q == '0);
              out_d.status = clamp_q ? krt_pkg::ST_CLAMPED : krt_pkg::ST_OK;
              if (n_q != '0) begin
                out_d = out_q;
              end
            end
          endcase
          out_d.used = count_d;
          if (!out_valid_d) begin
            out_d       = out_q;
            out_valid_d = out_valid_q && !m_axis_tready;
          end
        end
      end
      default: begin
        state_d = IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        step_q  <= '0;
        found_q <= 1'b0;
      end else begin
        if (shift) begin
          step_q <= step_q + IdxW'(1);
        end
        if (match) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  // Request and capture registers
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (accept) begin
      req_q    <= krt_pkg::req_e'(s_axis_tuser);
      in_rec_q <= in_rec;
      if ({3'b0, count_q} < lc) begin
        n_q     <= count_q;
        clamp_q <= 1'b1;
      end else begin
        n_q     <= lc[CntW-1:0];
        clamp_q <= 1'b0;
      end
    end
    if (match) begin
      found_idx_q <= step_q;
      cap_q       <= head;
    end
    if ((state_q == SCAN) && ({1'b0, step_q} == count_dec)) begin
      last_rec_q <= head;
    end
  end

  // Pack the result word
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {4'b0, out_q.rec.grade_three, out_q.rec.id_three,
                          out_q.rec.grade_two, out_q.rec.id_two,
                          out_q.rec.grade_one, out_q.rec.id_one,
                          out_q.rec.year, out_q.rec.key,
                          out_q.used, out_q.slot, out_q.status};

  `KRT_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CntW'(Depth))
  `KRT_ASSERT_NXT(a_accept_scan, accept, state_q == SCAN)
  `KRT_ASSERT_NXT(a_scan_finish, shift && step_last, state_q == FINISH)
  `KRT_ASSERT_NXT(a_count_change, state_q != FINISH, $stable(count_q))

endmodule

// ===== tb/sv/keyed_record_table_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed record table unit testbench
// Drives add, delete, read and list requests into the table with random
// stalls on both channels. A scoreboard keeps its own copy of the table,
// predicts every result word and checks each word as it leaves the block.
// ----------------------------------------------------------------------------
module keyed_record_table_unit_tb;

  localparam int MaxListWords = 16;
  localparam int CycleLimit   = 400000;

  // Table model with a queue of predicted result words
  class record_table_board;
    krt_pkg::rec_t rec_store[krt_pkg::TableDepth];
    int unsigned   rec_count;
    logic [127:0]  word_q[$];
    logic          last_q[$];
    int unsigned   n_mismatch;

    function new();
      rec_count  = 0;
      n_mismatch = 0;
    endfunction

    function void push_word(krt_pkg::status_e st, int unsigned slot, logic last,
                            krt_pkg::rec_t rec);
      logic [127:0] w;
      w = '0;
      w[2:0]     = st;
      w[6:3]     = slot[3:0];
      w[11:7]    = rec_count[4:0];
      w[43:12]   = rec.key;
      w[51:44]   = rec.year;
      w[67:52]   = rec.id_one;
      w[75:68]   = rec.grade_one;
      w[91:76]   = rec.id_two;
      w[99:92]   = rec.grade_two;
      w[115:100] = rec.id_three;
      w[123:116] = rec.grade_three;
      word_q.push_back(w);
      last_q.push_back(last);
    endfunction

    function bit find_key(logic [31:0] key, output int unsigned slot);
      for (int unsigned i = 0; i < rec_count; i++) begin
        if (rec_store[i].key == key) begin
          slot = i;
          return 1;
        end
      end
      slot = 0;
      return 0;
    endfunction

    // Work out the result words of one accepted request
    function void note_request(krt_pkg::req_e req, logic [119:0] data);
      krt_pkg::rec_t    in_rec;
      krt_pkg::rec_t    blank;
      int unsigned      slot;
      int unsigned      n;
      krt_pkg::status_e st;
      blank  = '0;
      in_rec = '{key: data[31:0], year: data[39:32], id_one: data[55:40],
                 grade_one: data[63:56], id_two: data[79:64],
                 grade_two: data[87:80], id_three: data[103:88],
                 grade_three: data[111:104]};
      case (req)
        krt_pkg::REQ_ADD: begin
          if (rec_count >= krt_pkg::TableDepth)
            push_word(krt_pkg::ST_FULL, 0, 1'b1, blank);
          else if (find_key(in_rec.key, slot))
            push_word(krt_pkg::ST_DUP, slot, 1'b1, blank);
          else begin
            slot = rec_count;
            rec_store[slot] = in_rec;
            rec_count++;
            push_word(krt_pkg::ST_OK, slot, 1'b1, blank);
          end
        end
        krt_pkg::REQ_DEL: begin
          if (!find_key(in_rec.key, slot))
            push_word(krt_pkg::ST_MISSING, 0, 1'b1, blank);
          else begin
            // Fill the hole with the last record
            rec_store[slot] = rec_store[rec_count - 1];
            rec_count--;
            push_word(krt_pkg::ST_OK, slot, 1'b1, blank);
          end
        end
        krt_pkg::REQ_READ: begin
          if (!find_key(in_rec.key, slot))
            push_word(krt_pkg::ST_MISSING, 0, 1'b1, blank);
          else push_word(krt_pkg::ST_OK, slot, 1'b1, rec_store[slot]);
        end
        default: begin
          n  = 32'(data[119:112]);
          st = krt_pkg::ST_OK;
          if (n > rec_count) begin
            n  = rec_count;
            st = krt_pkg::ST_CLAMPED;
          end
          if (n > MaxListWords) begin
            n  = MaxListWords;
            st = krt_pkg::ST_CLAMPED;
          end
          if (n == 0) push_word(st, 0, 1'b1, blank);
          for (int unsigned i = 0; i < n; i++) begin
            blank.key = rec_store[i].key;
            push_word(st, i, (i + 1 == n), blank);
          end
        end
      endcase
    endfunction

    task report(string what, logic [127:0] got, logic [127:0] want);
      n_mismatch++;
      $display("[%0t] %s: got %h expected %h", $time, what, got, want);
    endtask

    // Compare one result word with the oldest prediction
    task check_word(logic [127:0] data, logic last);
      logic [127:0] w;
      logic         l;
      if (word_q.size() == 0) begin
        report("unexpected word", data, '0);
        return;
      end
      w = word_q.pop_front();
      l = last_q.pop_front();
      if (data[2:0] !== w[2:0]) report("status", data, w);
      if (data[6:3] !== w[6:3]) report("slot index", data, w);
      if (data[11:7] !== w[11:7]) report("used count", data, w);
      if (data[43:12] !== w[43:12]) report("key", data, w);
      if (data[123:44] !== w[123:44]) report("record fields", data, w);
      if (data[127:124] !== w[127:124]) report("fill bits", data, w);
      if (last !== l) report("tlast", {127'd0, last}, {127'd0, l});
    endtask
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = krt_pkg::REQ_ADD;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic         m_axis_tlast;

  record_table_board board = new();
  logic [31:0] key_pool[24];
  int unsigned cycle_cnt = 0;
  bit          calm = 1'b0;

  keyed_record_table_unit dut (.*);

  always #5 clk_i = ~clk_i;

  // Check each word leaving the block and stall the receiver at random
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_word(m_axis_tdata, m_axis_tlast);
    m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 8);
  end

  // Give up on a hung run
  always @(posedge clk_i) begin
    if (cycle_cnt > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [119:0] pack_req(logic [31:0] key, logic [7:0] cnt, bit full_ones);
    logic [119:0] d;
    d = full_ones ? {120{1'b1}} : 120'({$urandom, $urandom, $urandom, $urandom});
    d[31:0]    = key;
    d[119:112] = cnt;
    return d;
  endfunction

  // Hand one word to the block, with an occasional gap before it
  task automatic send(krt_pkg::req_e req, logic [119:0] data);
    if (!calm && $urandom_range(99) < 8) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    board.note_request(req, data);
  endtask

  function automatic logic [31:0] pick_key();
    return ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(23)];
  endfunction

  initial begin
    krt_pkg::req_e r;
    logic [7:0]    cnt;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, extremes, duplicates, missing keys, full table
    send(krt_pkg::REQ_LIST, pack_req('0, 8'd0, 0));
    send(krt_pkg::REQ_LIST, pack_req('0, 8'd255, 0));
    send(krt_pkg::REQ_READ, pack_req('0, 8'd0, 0));
    send(krt_pkg::REQ_DEL, pack_req('1, 8'd0, 0));
    send(krt_pkg::REQ_ADD, {120{1'b0}});
    send(krt_pkg::REQ_ADD, pack_req('1, 8'd255, 1));
    send(krt_pkg::REQ_ADD, pack_req('1, 8'd0, 0));
    send(krt_pkg::REQ_READ, pack_req('1, 8'd0, 0));
    send(krt_pkg::REQ_READ, pack_req('0, 8'd0, 0));
    send(krt_pkg::REQ_LIST, pack_req('0, 8'd1, 0));
    for (int i = 2; i < 16; i++) send(krt_pkg::REQ_ADD, pack_req(key_pool[i], 8'd0, 0));
    send(krt_pkg::REQ_ADD, pack_req(key_pool[20], 8'd0, 0));
    send(krt_pkg::REQ_LIST, pack_req('0, 8'd16, 0));
    send(krt_pkg::REQ_LIST, pack_req('0, 8'd255, 1));
    send(krt_pkg::REQ_DEL, pack_req('0, 8'd0, 0));
    send(krt_pkg::REQ_DEL, pack_req(key_pool[15], 8'd0, 0));
    send(krt_pkg::REQ_READ, pack_req(key_pool[14], 8'd0, 0));

    // Random traffic over a small key pool so hits are common
    for (int i = 0; i < 230; i++) begin
      calm = (i >= 90 && i < 140);
      case ($urandom_range(9))
        0, 1, 2, 3: r = krt_pkg::REQ_ADD;
        4, 5:       r = krt_pkg::REQ_DEL;
        6, 7, 8:    r = krt_pkg::REQ_READ;
        default:    r = krt_pkg::REQ_LIST;
      endcase
      cnt = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(17));
      send(r, pack_req(pick_key(), cnt, 0));
    end
    s_axis_tvalid <= 1'b0;
    calm = 1'b0;

    wait (board.word_q.size() == 0);
    repeat (40) @(posedge clk_i);
    if (board.n_mismatch == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// ===== keyed_record_table_unit.f =====
+incdir+src
src/krt_pkg.sv
src/krt_cell.sv
src/keyed_record_table_unit.sv
tb/sv/keyed_record_table_unit_tb.sv
